>>> hdl/gre_pkg.sv
// Shared types, constants and helpers for the gamepad report event generator.
// No dependencies; used by every module of the block.
package gre_pkg;

  localparam int NUM_BTN   = 14;
  localparam int NUM_EV    = 20;
  localparam int EV_IDX_W  = 5;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  // Slot positions in a job's pending-event mask
  localparam logic [EV_IDX_W-1:0] SLOT_BTN0  = 5'd4;
  localparam logic [EV_IDX_W-1:0] SLOT_TRIG0 = 5'd18;

  // Event codes
  localparam logic [5:0] EC_BTN_BASE  = 6'd4;
  localparam logic [5:0] EC_TRIG_BASE = 6'd32;

  // Register indexes (address bit 2)
  localparam logic REG_DEADZONE = 1'b0;
  localparam logic REG_CTRL_IDX = 1'b1;

  typedef struct packed {
    logic [31:0]          tag;
    logic [3:0][15:0]     axes;     // lx, ly, rx, ry
    logic [3:0][16:0]     delta;    // stick deltas, same order
    logic [NUM_BTN-1:0]   btn_now;  // current level of the reported buttons
    logic [1:0][8:0]      trig_d;   // trigger deltas, left then right
    logic [NUM_EV-1:0]    pend;     // events still to send, lowest first
  } job_t;

  // Reported buttons: mask bits 0..9 and 12..15
  function automatic logic [NUM_BTN-1:0] btn_sel(input logic [15:0] b);
    btn_sel = {b[15:12], b[9:0]};
  endfunction

  function automatic logic [16:0] sext16(input logic [15:0] v);
    sext16 = {v[15], v};
  endfunction

endpackage

>>> hdl/gre_front.sv
// Front end: accepts reports, compares against the stored report and builds a job.
// Depends on gre_pkg.
module gre_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_focused,
  input  logic               in_read_ok,
  input  logic [31:0]        in_request_tag,
  input  logic [31:0]        in_packet_number,
  input  logic [15:0]        in_buttons,
  input  logic [7:0]         in_trigger_left,
  input  logic [7:0]         in_trigger_right,
  input  logic signed [15:0] in_stick_left_x,
  input  logic signed [15:0] in_stick_left_y,
  input  logic signed [15:0] in_stick_right_x,
  input  logic signed [15:0] in_stick_right_y,
  input  logic [15:0]        deadzone,
  input  logic               q_full,
  output logic               q_push,
  output gre_pkg::job_t      q_job
);

  logic [31:0]       last_packet_r;
  logic [15:0]       last_buttons_r;
  logic [1:0][7:0]   last_trig_r;
  logic [3:0][15:0]  last_axes_r;

  logic              accept;
  logic [3:0][15:0]  ax;
  logic [1:0][7:0]   trig;
  logic [3:0][16:0]  dlt;
  logic [3:0][16:0]  mag;
  logic [3:0]        over;
  logic              changed;
  logic [gre_pkg::NUM_BTN-1:0] b_now, b_was;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && in_focused && in_read_ok;

  assign ax   = {in_stick_right_y, in_stick_right_x, in_stick_left_y, in_stick_left_x};
  assign trig = {in_trigger_right, in_trigger_left};
  assign changed = in_packet_number != last_packet_r;
  assign b_now = gre_pkg::btn_sel(in_buttons);
  assign b_was = gre_pkg::btn_sel(last_buttons_r);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dlt[i]  = gre_pkg::sext16(ax[i]) - gre_pkg::sext16(last_axes_r[i]);
      mag[i]  = dlt[i][16] ? (~dlt[i] + 17'd1) : dlt[i];
      over[i] = mag[i] > {1'b0, deadzone};
    end
  end

  always_comb begin
    q_job.tag     = in_request_tag;
    q_job.axes    = ax;
    q_job.delta   = dlt;
    q_job.btn_now = b_now;
    for (int t = 0; t < 2; t++) begin
      q_job.trig_d[t] = {1'b0, trig[t]} - {1'b0, last_trig_r[t]};
    end
    q_job.pend       = '0;
    q_job.pend[1:0]  = 2'b11;
    if (changed) begin
      q_job.pend[2]     = over[0] || over[1];
      q_job.pend[3]     = over[2] || over[3];
      q_job.pend[17:4]  = b_now ^ b_was;
      q_job.pend[18]    = trig[0] != last_trig_r[0];
      q_job.pend[19]    = trig[1] != last_trig_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_packet_r  <= '0;
      last_buttons_r <= '0;
      last_trig_r    <= '0;
      last_axes_r    <= '0;
    end else if (q_push) begin
      last_packet_r  <= in_packet_number;
      last_buttons_r <= in_buttons;
      last_trig_r    <= trig;
      last_axes_r    <= ax;
    end
  end

endmodule

>>> hdl/gre_queue.sv
// Two-entry job queue between the front end and the event sequencer.
// Depends on gre_pkg.
module gre_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gre_pkg::job_t wdata,
  input  logic          pop,
  output gre_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  gre_pkg::job_t                 mem_r [gre_pkg::QDEPTH];
  logic [gre_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [gre_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full  = cnt_r == gre_pkg::QCNT_W'(gre_pkg::QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)
      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

>>> hdl/gre_back.sv
// Event sequencer: walks a job's pending mask and sends one event per transfer.
// Depends on gre_pkg.
module gre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  gre_pkg::job_t      q_data,
  output logic               q_pop,
  input  logic [1:0]         controller_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_event_code,
  output logic signed [16:0] out_value_x,
  output logic signed [16:0] out_value_y,
  output logic [31:0]        out_tag_out,
  output logic [1:0]         out_controller_out,
  output logic               out_last
);

  gre_pkg::job_t               cur_r;
  logic [gre_pkg::NUM_EV-1:0]  pend_r, pend_nxt, lowbit, pend_left;
  logic                        out_valid_r;
  logic [5:0]                  code_r;
  logic [16:0]                 vx_r, vy_r;
  logic [31:0]                 tag_r;
  logic [1:0]                  ctl_r;
  logic                        last_r;

  logic                        busy, can_emit, job_done;
  logic [gre_pkg::EV_IDX_W-1:0] idx;
  logic [3:0]                  bi;
  logic                        ti;
  logic [5:0]                  code;
  logic [16:0]                 vx, vy;

  assign busy      = |pend_r;
  assign can_emit  = busy && (!out_valid_r || out_ready);
  assign lowbit    = pend_r & (~pend_r + 1'b1);
  assign pend_left = pend_r & ~lowbit;
  assign job_done  = !busy || (can_emit && pend_left == '0);
  assign q_pop     = job_done && !q_empty;

  // lowest pending slot
  always_comb begin
    idx = '0;
    for (int k = gre_pkg::NUM_EV - 1; k >= 0; k--) begin
      if (pend_r[k]) idx = gre_pkg::EV_IDX_W'(k);
    end
  end

  assign bi = 4'(idx - gre_pkg::SLOT_BTN0);
  assign ti = idx[0];  // SLOT_TRIG0 is even

  always_comb begin
    code = 6'(idx);
    vx   = '0;
    vy   = '0;
    if (idx < gre_pkg::SLOT_BTN0) begin
      vx = idx[1] ? cur_r.delta[{idx[0], 1'b0}] : gre_pkg::sext16(cur_r.axes[{idx[0], 1'b0}]);
      vy = idx[1] ? cur_r.delta[{idx[0], 1'b1}] : gre_pkg::sext16(cur_r.axes[{idx[0], 1'b1}]);
    end else if (idx < gre_pkg::SLOT_TRIG0) begin
      code = gre_pkg::EC_BTN_BASE + 6'({bi, 1'b0}) + 6'(!cur_r.btn_now[bi]);
    end else begin
      code = gre_pkg::EC_TRIG_BASE + 6'({ti, 1'b0}) + 6'(cur_r.trig_d[ti][8]);
      vx   = {{8{cur_r.trig_d[ti][8]}}, cur_r.trig_d[ti]};
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (q_pop)
      pend_nxt = q_data.pend;
    else if (can_emit)
      pend_nxt = pend_left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (can_emit)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_data;
    if (can_emit) begin
      code_r <= code;
      vx_r   <= vx;
      vy_r   <= vy;
      tag_r  <= cur_r.tag;
      ctl_r  <= controller_index;
      last_r <= pend_left == '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_code     = code_r;
  assign out_value_x        = vx_r;
  assign out_value_y        = vy_r;
  assign out_tag_out        = tag_r;
  assign out_controller_out = ctl_r;
  assign out_last           = last_r;

endmodule

>>> hdl/gamepad_report_event_generator_top.sv
// A report's first event passes the job queue, job registers and output registers.
// Throughput: one event per cycle while out_ready is high; a report with n events
// (2..20) holds the sequencer; a two-entry job queue lets reports arrive meanwhile.
// Reset (rst_n low, synchronous): config, stored report, queue pointers, pending mask and out_valid clear.
// Top level: configuration registers, front end, job queue and sequencer.
// Depends on gre_pkg, gre_front, gre_queue, gre_back.
module gamepad_report_event_generator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_focused,
  input  logic               in_read_ok,
  input  logic [31:0]        in_request_tag,
  input  logic [31:0]        in_packet_number,
  input  logic [15:0]        in_buttons,
  input  logic [7:0]         in_trigger_left,
  input  logic [7:0]         in_trigger_right,
  input  logic signed [15:0] in_stick_left_x,
  input  logic signed [15:0] in_stick_left_y,
  input  logic signed [15:0] in_stick_right_x,
  input  logic signed [15:0] in_stick_right_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_event_code,
  output logic signed [16:0] out_value_x,
  output logic signed [16:0] out_value_y,
  output logic [31:0]        out_tag_out,
  output logic [1:0]         out_controller_out,
  output logic               out_last
);

  logic [15:0]   deadzone_r;
  logic [1:0]    ctrl_idx_r;
  logic          cfg_wr;

  logic          q_push, q_pop, q_full, q_empty;
  gre_pkg::job_t q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= '0;
      ctrl_idx_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == gre_pkg::REG_DEADZONE) deadzone_r <= pwdata[15:0];
      if (paddr[2] == gre_pkg::REG_CTRL_IDX) ctrl_idx_r <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == gre_pkg::REG_DEADZONE) ? {16'd0, deadzone_r}
                                                      : {30'd0, ctrl_idx_r};

  gre_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_focused       (in_focused),
    .in_read_ok       (in_read_ok),
    .in_request_tag   (in_request_tag),
    .in_packet_number (in_packet_number),
    .in_buttons       (in_buttons),
    .in_trigger_left  (in_trigger_left),
    .in_trigger_right (in_trigger_right),
    .in_stick_left_x  (in_stick_left_x),
    .in_stick_left_y  (in_stick_left_y),
    .in_stick_right_x (in_stick_right_x),
    .in_stick_right_y (in_stick_right_y),
    .deadzone         (deadzone_r),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (q_wdata)
  );

  gre_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  gre_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_pop              (q_pop),
    .controller_index   (ctrl_idx_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_code     (out_event_code),
    .out_value_x        (out_value_x),
    .out_value_y        (out_value_y),
    .out_tag_out        (out_tag_out),
    .out_controller_out (out_controller_out),
    .out_last           (out_last)
  );

endmodule

>>> hdl/gre_checker.sv
// Port-level checks for the gamepad report event generator, bound to the top.
// Depends on gamepad_report_event_generator_top ports only.
module gre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [5:0]  out_event_code,
  input logic [16:0] out_value_x,
  input logic [16:0] out_value_y,
  input logic [31:0] out_tag_out,
  input logic        out_last
);

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code) &&
      $stable(out_value_x) && $stable(out_value_y) && $stable(out_tag_out) &&
      $stable(out_last))
    else $error("output changed while stalled");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= 6'd35)
    else $error("event code out of range");

  a_btn_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code >= 6'd4 && out_event_code <= 6'd31 |->
      out_value_x == '0 && out_value_y == '0)
    else $error("button event with nonzero value");

  // left stick position is always followed by right stick position
  a_pos_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code == 6'd0 |-> !out_last)
    else $error("left position flagged last");

endmodule

bind gamepad_report_event_generator_top gre_checker u_gre_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_event_code (out_event_code),
  .out_value_x    (out_value_x),
  .out_value_y    (out_value_y),
  .out_tag_out    (out_tag_out),
  .out_last       (out_last)
);
